[rtl/bfdt_pkg.sv]
`default_nettype none
package bfdt_pkg;

   localparam int unsigned STORE_AW  = 16;
   localparam logic [15:0] FAR_DEPTH = 16'hFFFF;

   // Widths of the exact products
   localparam int unsigned DW  = 18;   // coordinate differences
   localparam int unsigned NW  = 36;   // D, Nw, Nv, Nu
   localparam int unsigned SW  = 54;   // weighted depth sum
   localparam int unsigned QW  = 56;   // numerator / denominator for the divider

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_DIFF,
      ST_PROD,
      ST_NUM,
      ST_WPROD,
      ST_WSUM,
      ST_DIV,
      ST_READ,
      ST_TEST,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

[rtl/barycentric_fragment_depth_test.sv]
// Fragment transactions: the 56-step restoring divider forms the rounded depth quotient
//   that becomes the fragment depth.
// One transaction at a time: busy stays high through the result strobe, so a new
//   fragment is taken only after the last one's result. The receiver cannot stall: rsp_valid is a strobe.
// A clear transaction strobes its result in the cycle after acceptance, then sweeps the depth
//   memory one entry per cycle, busy throughout; reset runs the same sweep.
`default_nettype none
module barycentric_fragment_depth_test #(
   parameter int unsigned SCREEN_WIDTH  = 256,
   parameter int unsigned SCREEN_HEIGHT = 256
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  wire                req_mode,
   input  wire signed [15:0]  req_vert_a_x,
   input  wire signed [15:0]  req_vert_a_y,
   input  wire        [15:0]  req_vert_a_depth,
   input  wire signed [15:0]  req_vert_b_x,
   input  wire signed [15:0]  req_vert_b_y,
   input  wire        [15:0]  req_vert_b_depth,
   input  wire signed [15:0]  req_vert_c_x,
   input  wire signed [15:0]  req_vert_c_y,
   input  wire        [15:0]  req_vert_c_depth,
   input  wire        [11:0]  req_pixel_x,
   input  wire        [11:0]  req_pixel_y,
   output logic               rsp_valid,
   output logic               rsp_covered,
   output logic               rsp_drawn,
   output logic       [15:0]  rsp_frag_depth
);

   localparam int unsigned DW = bfdt_pkg::DW;
   localparam int unsigned NW = bfdt_pkg::NW;
   localparam int unsigned SW = bfdt_pkg::SW;
   localparam int unsigned QW = bfdt_pkg::QW;
   localparam int unsigned AW = bfdt_pkg::STORE_AW;
   localparam int unsigned DIV_STEPS = QW;
   localparam int unsigned CW = $clog2(DIV_STEPS + 1);

   bfdt_pkg::state_type state_ff, state_in;

   logic [15:0] mem [0:(1 << AW) - 1];
   logic [15:0] rdata_ff;

   // captured item
   logic signed [15:0] ax_ff, ay_ff, bx_ff, by_ff, cx_ff, cy_ff;
   logic        [15:0] za_ff, zb_ff, zc_ff;
   logic        [11:0] pxi_ff, pyi_ff;

   // differences
   logic signed [DW-1:0] d_bc_y_ff, d_ac_x_ff, d_cb_x_ff, d_ac_y_ff;
   logic signed [DW-1:0] d_pc_x_ff, d_pc_y_ff, d_ca_y_ff;
   logic signed [DW-1:0] d_bc_y_in, d_ac_x_in, d_cb_x_in, d_ac_y_in;
   logic signed [DW-1:0] d_pc_x_in, d_pc_y_in, d_ca_y_in;

   // products
   logic signed [NW-1:0] p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;
   logic signed [NW-1:0] den_ff, nw_ff, nv_ff, nu_ff;
   logic signed [SW-1:0] wa_ff, wb_ff, wc_ff;

   // divider
   logic [QW-1:0] rem_ff, rem_in, quo_ff, quo_in, divisor_ff, divisor_in;
   logic          num_neg_ff, num_neg_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic          covered_ff, covered_in, inside_ff, inside_in;
   logic [15:0]   depth_ff, depth_in;

   logic          rsp_valid_in, rsp_covered_in, rsp_drawn_in;
   logic [15:0]   rsp_depth_in;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [15:0]   mem_wdata;

   logic signed [SW-1:0] sum_s;
   logic signed [QW-1:0] num_s, den2_s;
   logic [QW-1:0]        trial;
   logic [QW-1:0]        rem_sh;
   logic [QW-1:0]        qmag;
   logic signed [QW:0]   qval;
   logic [AW+12:0]       lin_idx;

   function automatic logic in_unit(input logic signed [NW-1:0] n,
                                    input logic signed [NW-1:0] d);
      if (d > 0) begin
         return (n >= 0) && (n <= d);
      end
      return (n <= 0) && (n >= d);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= bfdt_pkg::ST_CLEAR;
         addr_ff   <= '0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff  <= state_in;
         addr_ff   <= addr_in;
         rsp_valid <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         ax_ff  <= req_vert_a_x;  ay_ff <= req_vert_a_y;  za_ff <= req_vert_a_depth;
         bx_ff  <= req_vert_b_x;  by_ff <= req_vert_b_y;  zb_ff <= req_vert_b_depth;
         cx_ff  <= req_vert_c_x;  cy_ff <= req_vert_c_y;  zc_ff <= req_vert_c_depth;
         pxi_ff <= req_pixel_x;   pyi_ff <= req_pixel_y;
      end
      d_bc_y_ff <= d_bc_y_in; d_ac_x_ff <= d_ac_x_in; d_cb_x_ff <= d_cb_x_in;
      d_ac_y_ff <= d_ac_y_in; d_pc_x_ff <= d_pc_x_in; d_pc_y_ff <= d_pc_y_in;
      d_ca_y_ff <= d_ca_y_in;
      p0_ff <= NW'(d_bc_y_ff * d_ac_x_ff);
      p1_ff <= NW'(d_cb_x_ff * d_ac_y_ff);
      p2_ff <= NW'(d_bc_y_ff * d_pc_x_ff);
      p3_ff <= NW'(d_cb_x_ff * d_pc_y_ff);
      p4_ff <= NW'(d_ca_y_ff * d_pc_x_ff);
      p5_ff <= NW'(d_ac_x_ff * d_pc_y_ff);
      if (state_ff == bfdt_pkg::ST_NUM) begin
         den_ff <= p0_ff + p1_ff;
         nw_ff  <= p2_ff + p3_ff;
         nv_ff  <= p4_ff + p5_ff;
      end
      if (state_ff == bfdt_pkg::ST_WPROD) begin
         nu_ff <= den_ff - nw_ff - nv_ff;
      end
      if (state_ff == bfdt_pkg::ST_WSUM) begin
         wa_ff <= SW'($signed({1'b0, za_ff}) * nw_ff);
         wb_ff <= SW'($signed({1'b0, zb_ff}) * nv_ff);
         wc_ff <= SW'($signed({1'b0, zc_ff}) * nu_ff);
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
      num_neg_ff <= num_neg_in;
      cnt_ff     <= cnt_in;
      covered_ff <= covered_in;
      inside_ff  <= inside_in;
      depth_ff   <= depth_in;
      rsp_covered    <= rsp_covered_in;
      rsp_drawn      <= rsp_drawn_in;
      rsp_frag_depth <= rsp_depth_in;
   end

   assign d_bc_y_in = DW'(by_ff) - DW'(cy_ff);
   assign d_ac_x_in = DW'(ax_ff) - DW'(cx_ff);
   assign d_cb_x_in = DW'(cx_ff) - DW'(bx_ff);
   assign d_ac_y_in = DW'(ay_ff) - DW'(cy_ff);
   assign d_ca_y_in = DW'(cy_ff) - DW'(ay_ff);
   assign d_pc_x_in = DW'($signed({1'b0, pxi_ff, 4'b0})) - DW'(cx_ff);
   assign d_pc_y_in = DW'($signed({1'b0, pyi_ff, 4'b0})) - DW'(cy_ff);

   // wa + wb + wc, sign-folded into numerator 2*sum + |den| and divisor 2*|den|
   assign sum_s  = wa_ff + wb_ff + wc_ff;
   assign num_s  = (den_ff < 0) ? (QW'(-den_ff) - (QW'(sum_s) <<< 1))
                                : ((QW'(sum_s) <<< 1) + QW'(den_ff));
   assign den2_s = (den_ff < 0) ? (QW'(-den_ff) <<< 1) : (QW'(den_ff) <<< 1);

   assign rem_sh = {rem_ff[QW-2:0], quo_ff[QW-1]};
   assign trial  = rem_sh - divisor_ff;

   // floor for negative numerators: -(ceil(|n|/d))
   assign qmag = quo_ff + QW'(num_neg_ff && (rem_ff != '0));
   assign qval = num_neg_ff ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});

   assign lin_idx = (AW+13)'(pyi_ff) * (AW+13)'(SCREEN_WIDTH) + (AW+13)'(pxi_ff);

   always_comb begin
      state_in       = state_ff;
      addr_in        = addr_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      divisor_in     = divisor_ff;
      num_neg_in     = num_neg_ff;
      cnt_in         = cnt_ff;
      covered_in     = covered_ff;
      inside_in      = inside_ff;
      depth_in       = depth_ff;
      rsp_valid_in   = 1'b0;
      rsp_covered_in = rsp_covered;
      rsp_drawn_in   = rsp_drawn;
      rsp_depth_in   = rsp_frag_depth;
      mem_we         = 1'b0;
      mem_waddr      = addr_ff;
      mem_wdata      = bfdt_pkg::FAR_DEPTH;
      busy           = (state_ff != bfdt_pkg::ST_IDLE);
      unique case (state_ff)
         bfdt_pkg::ST_IDLE: begin
            if (start) begin
               if (!req_mode) begin
                  addr_in  = '0;
                  state_in = bfdt_pkg::ST_CLEAR;
                  rsp_valid_in   = 1'b1;
                  rsp_covered_in = 1'b0;
                  rsp_drawn_in   = 1'b0;
                  rsp_depth_in   = '0;
               end else begin
                  state_in = bfdt_pkg::ST_DIFF;
               end
            end
         end
         bfdt_pkg::ST_CLEAR: begin
            mem_we  = 1'b1;
            addr_in = addr_ff + 1'b1;
            if (addr_ff == '1) begin
               state_in = bfdt_pkg::ST_IDLE;
            end
         end
         bfdt_pkg::ST_DIFF:  state_in = bfdt_pkg::ST_PROD;
         bfdt_pkg::ST_PROD:  state_in = bfdt_pkg::ST_NUM;
         bfdt_pkg::ST_NUM:   state_in = bfdt_pkg::ST_WPROD;
         bfdt_pkg::ST_WPROD: begin
            covered_in = 1'b0;
            state_in   = bfdt_pkg::ST_WSUM;
         end
         bfdt_pkg::ST_WSUM: begin
            covered_in = in_unit(nw_ff, den_ff) && in_unit(nv_ff, den_ff) &&
                         in_unit(nu_ff, den_ff) && (den_ff != '0);
            inside_in  = (pxi_ff != '0) && (32'(pxi_ff) < SCREEN_WIDTH) &&
                         (pyi_ff != '0) && (32'(pyi_ff) < SCREEN_HEIGHT);
            addr_in    = lin_idx[AW-1:0];
            state_in   = bfdt_pkg::ST_DIV;
            cnt_in     = '0;
            rem_in     = '0;
         end
         bfdt_pkg::ST_DIV: begin
            if (cnt_ff == '0) begin
               num_neg_in = num_s < 0;
               quo_in     = (num_s < 0) ? QW'(-num_s) : QW'(num_s);
               divisor_in = den2_s;
               rem_in     = '0;
               cnt_in     = cnt_ff + 1'b1;
            end else begin
               if (rem_sh >= divisor_ff) begin
                  rem_in = trial;
                  quo_in = {quo_ff[QW-2:0], 1'b1};
               end else begin
                  rem_in = rem_sh;
                  quo_in = {quo_ff[QW-2:0], 1'b0};
               end
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == CW'(DIV_STEPS)) begin
                  state_in = bfdt_pkg::ST_READ;
               end
            end
         end
         bfdt_pkg::ST_READ: begin
            if (den_ff == '0 || qval < 0) begin
               depth_in = '0;
            end else if (qval > $signed({1'b0, QW'(bfdt_pkg::FAR_DEPTH)})) begin
               depth_in = bfdt_pkg::FAR_DEPTH;
            end else begin
               depth_in = qval[15:0];
            end
            state_in = bfdt_pkg::ST_TEST;
         end
         bfdt_pkg::ST_TEST: begin
            rsp_valid_in   = 1'b1;
            rsp_covered_in = covered_ff;
            rsp_depth_in   = depth_ff;
            rsp_drawn_in   = covered_ff && inside_ff && (depth_ff < rdata_ff);
            if (rsp_drawn_in) begin
               mem_we    = 1'b1;
               mem_wdata = depth_ff;
            end
            state_in = bfdt_pkg::ST_DONE;
         end
         bfdt_pkg::ST_DONE:  state_in = bfdt_pkg::ST_IDLE;
         default:            state_in = bfdt_pkg::ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

[rtl/bfdt_checker.sv]
`default_nettype none
module bfdt_checker (
   input wire        clock,
   input wire        reset,
   input wire        start,
   input wire        busy,
   input wire        req_mode,
   input wire        rsp_valid,
   input wire        rsp_covered,
   input wire        rsp_drawn,
   input wire [15:0] rsp_frag_depth
);

   a_drawn_needs_cover: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_drawn |-> rsp_covered)
      else $error("drawn without coverage");

   a_clear_result: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_mode |=> rsp_valid && !rsp_covered && !rsp_drawn
         && rsp_frag_depth == 16'd0)
      else $error("clear result wrong");

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("double result strobe");

endmodule

bind barycentric_fragment_depth_test bfdt_checker u_bfdt_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .req_mode(req_mode),
   .rsp_valid(rsp_valid), .rsp_covered(rsp_covered), .rsp_drawn(rsp_drawn),
   .rsp_frag_depth(rsp_frag_depth)
);
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
`default_nettype none
class depth_scoreboard;
   logic [15:0] zbuf [0:65535];
   bit          exp_cov [$];
   bit          exp_drawn [$];
   logic [15:0] exp_depth [$];
   int          errors;
   int          n_checked;
   int          n_drawn;
   int          n_cov;

   function new();
      errors = 0;
      n_checked = 0;
      n_drawn = 0;
      n_cov = 0;
      wipe();
   endfunction

   function void wipe();
      for (int i = 0; i < 65536; i++) zbuf[i] = 16'hFFFF;
   endfunction

   function bit in_unit(longint num, longint den);
      if (den > 0) return num >= 0 && num <= den;
      return num <= 0 && num >= den;
   endfunction

   // predict one accepted transaction
   function void note_request(bit mode, shortint ax, shortint ay, logic [15:0] za,
                              shortint bx, shortint by, logic [15:0] zb,
                              shortint cx, shortint cy, logic [15:0] zc,
                              logic [11:0] pxi, logic [11:0] pyi);
      longint den, nw, nv, nu, sum, q, px, py, num2;
      bit cov, drw;
      logic [15:0] dep;
      int idx;
      cov = 0;
      drw = 0;
      dep = 0;
      if (!mode) begin
         wipe();
      end else begin
         px = longint'(pxi) * 16;
         py = longint'(pyi) * 16;
         den = (longint'(by) - cy) * (longint'(ax) - cx) + (longint'(cx) - bx) * (longint'(ay) - cy);
         if (den != 0) begin
            nw = (longint'(by) - cy) * (px - cx) + (longint'(cx) - bx) * (py - cy);
            nv = (longint'(cy) - ay) * (px - cx) + (longint'(ax) - cx) * (py - cy);
            nu = den - nw - nv;
            cov = in_unit(nw, den) && in_unit(nv, den) && in_unit(nu, den);
            sum = longint'(za) * nw + longint'(zb) * nv + longint'(zc) * nu;
            if (den < 0) begin
               sum = -sum;
               den = -den;
            end
            num2 = 2 * sum + den;
            if (num2 >= 0) q = num2 / (2 * den);
            else q = -((-num2 + 2 * den - 1) / (2 * den));
            if (q < 0) q = 0;
            if (q > 65535) q = 65535;
            dep = q[15:0];
            if (cov && pxi > 0 && pxi < 256 && pyi > 0 && pyi < 256) begin
               idx = (int'(pyi) * 256 + int'(pxi)) & 16'hFFFF;
               if (dep < zbuf[idx]) begin
                  zbuf[idx] = dep;
                  drw = 1;
               end
            end
         end
      end
      exp_cov = {exp_cov, cov};
      exp_drawn = {exp_drawn, drw};
      exp_depth = {exp_depth, dep};
   endfunction

   function void check_result(bit cov, bit drw, logic [15:0] dep);
      bit ec, ed;
      logic [15:0] ez;
      if (exp_cov.size() == 0) begin
         $display("%0t: unexpected result cov=%0b drawn=%0b depth=%0d", $time, cov, drw, dep);
         errors++;
         return;
      end
      ec = exp_cov.pop_front();
      ed = exp_drawn.pop_front();
      ez = exp_depth.pop_front();
      n_checked++;
      if (ed) n_drawn++;
      if (ec) n_cov++;
      if (cov !== ec) begin
         $display("%0t: covered expected %0b actual %0b", $time, ec, cov);
         errors++;
      end
      if (drw !== ed) begin
         $display("%0t: drawn expected %0b actual %0b", $time, ed, drw);
         errors++;
      end
      if (dep !== ez) begin
         $display("%0t: frag_depth expected %0d actual %0d", $time, ez, dep);
         errors++;
      end
   endfunction
endclass

module tb_top;
   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic req_mode = 1;
   logic signed [15:0] req_vert_a_x = 0, req_vert_a_y = 0, req_vert_b_x = 0;
   logic signed [15:0] req_vert_b_y = 0, req_vert_c_x = 0, req_vert_c_y = 0;
   logic [15:0] req_vert_a_depth = 0, req_vert_b_depth = 0, req_vert_c_depth = 0;
   logic [11:0] req_pixel_x = 0, req_pixel_y = 0;
   logic rsp_valid, rsp_covered, rsp_drawn;
   logic [15:0] rsp_frag_depth;
   depth_scoreboard sb;
   int n_clears = 0;

   barycentric_fragment_depth_test uut (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_covered, rsp_drawn, rsp_frag_depth);
      if (!reset && start && !busy)
         sb.note_request(req_mode, req_vert_a_x, req_vert_a_y, req_vert_a_depth,
                         req_vert_b_x, req_vert_b_y, req_vert_b_depth,
                         req_vert_c_x, req_vert_c_y, req_vert_c_depth,
                         req_pixel_x, req_pixel_y);
   end

   // present one transaction and hold it until accepted
   task automatic send(bit mode, shortint ax, shortint ay, logic [15:0] za,
                       shortint bx, shortint by, logic [15:0] zb,
                       shortint cx, shortint cy, logic [15:0] zc,
                       logic [11:0] pxi, logic [11:0] pyi);
      req_mode <= mode;
      req_vert_a_x <= ax; req_vert_a_y <= ay; req_vert_a_depth <= za;
      req_vert_b_x <= bx; req_vert_b_y <= by; req_vert_b_depth <= zb;
      req_vert_c_x <= cx; req_vert_c_y <= cy; req_vert_c_depth <= zc;
      req_pixel_x <= pxi; req_pixel_y <= pyi;
      start <= 1;
      do @(posedge clock); while (busy);
      @(negedge clock);
      if (!mode) n_clears++;
   endtask

   task automatic idle(int n);
      start <= 0;
      repeat (n) @(negedge clock);
   endtask

   task automatic send_frag(shortint ax, shortint ay, logic [15:0] za,
                            shortint bx, shortint by, logic [15:0] zb,
                            shortint cx, shortint cy, logic [15:0] zc,
                            logic [11:0] pxi, logic [11:0] pyi);
      send(1, ax, ay, za, bx, by, zb, cx, cy, zc, pxi, pyi);
   endtask

   // random triangle near the screen, pixel mostly inside its box
   task automatic send_random_tri();
      int span, x0, y0;
      shortint ax, ay, bx, by, cx, cy;
      logic [11:0] pxi, pyi;
      span = ($urandom_range(0, 3) == 0) ? 4096 : 400;
      x0 = $urandom_range(0, 4095);
      y0 = $urandom_range(0, 4095);
      ax = shortint'(x0 + $urandom_range(0, span) - span / 2);
      ay = shortint'(y0 + $urandom_range(0, span) - span / 2);
      bx = shortint'(x0 + $urandom_range(0, span) - span / 2);
      by = shortint'(y0 + $urandom_range(0, span) - span / 2);
      cx = shortint'(x0 + $urandom_range(0, span) - span / 2);
      cy = shortint'(y0 + $urandom_range(0, span) - span / 2);
      pxi = 12'((x0 + $urandom_range(0, span / 2) - span / 4) >>> 4);
      pyi = 12'((y0 + $urandom_range(0, span / 2) - span / 4) >>> 4);
      send_frag(ax, ay, 16'($urandom), bx, by, 16'($urandom), cx, cy, 16'($urandom),
                pxi, pyi);
   endtask

   initial begin
      sb = new();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed
      send_frag(0, 0, 100, 1600, 0, 200, 0, 1600, 300, 10, 10);
      send_frag(0, 0, 100, 1600, 0, 200, 0, 1600, 300, 10, 10);
      send_frag(0, 0, 50, 1600, 0, 50, 0, 1600, 50, 10, 10);
      send_frag(0, 0, 1, 1600, 0, 1, 0, 1600, 1, 0, 5);
      send_frag(0, 0, 1, 1600, 0, 1, 0, 1600, 1, 5, 0);
      send_frag(0, 0, 16'hFFFF, 4000, 0, 16'hFFFF, 0, 4000, 16'hFFFF, 20, 20);
      send_frag(0, 0, 5, 16, 16, 6, 32, 32, 7, 1, 1);
      send_frag(-32768, -32768, 0, 32767, -32768, 16'hFFFF, -32768, 32767, 0, 4095, 4095);
      send_frag(32767, 32767, 16'hFFFF, -32768, 32767, 0, 32767, -32768, 16'hFFFF, 0, 0);
      send_frag(0, 0, 0, 0, 1600, 65535, 1600, 0, 30000, 5, 5);
      send_frag(0, 0, 9000, 4095, 0, 9000, 0, 4095, 9000, 300, 2);
      send_frag(0, 0, 0, 4096, 0, 65535, 0, 4096, 65535, 255, 255);
      send_frag(0, 0, 0, 8192, 0, 65535, 0, 8192, 65535, 256, 256);
      send_frag(0, 0, 65535, 160, 0, 0, 0, 160, 0, 20, 20);
      send_frag(0, 0, 65535, 16, 0, 65535, 0, 16, 0, 1, 0);
      send(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_frag(0, 0, 100, 1600, 0, 200, 0, 1600, 300, 10, 10);
      send_frag(-1, -1, 16'hAAAA, 21845, -21846, 16'h5555, -21846, 21845, 16'h1234, 12'hAAA, 12'h555);
      // random
      for (int i = 0; i < 600; ) begin
         int burst;
         burst = $urandom_range(1, 12);
         for (int k = 0; k < burst && i < 600; k++, i++) begin
            if (i == 300) send(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
            else if ($urandom_range(0, 9) == 0)
               send_frag(shortint'($urandom), shortint'($urandom), 16'($urandom),
                         shortint'($urandom), shortint'($urandom), 16'($urandom),
                         shortint'($urandom), shortint'($urandom), 16'($urandom),
                         12'($urandom), 12'($urandom));
            else send_random_tri();
         end
         if ($urandom_range(0, 2) != 0) idle($urandom_range(1, 80));
      end
      start <= 0;
      while (sb.exp_cov.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      $display("Checked %0d results: %0d covered, %0d drawn, %0d clears.",
               sb.n_checked, sb.n_cov, sb.n_drawn, n_clears);
      if (sb.errors == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

   initial begin
      #2000000;
      $display("Timeout");
      $display("Test completed with failures");
      $finish;
   end
endmodule
`default_nettype wire

[sim.f]
rtl/bfdt_pkg.sv
rtl/barycentric_fragment_depth_test.sv
rtl/bfdt_checker.sv
tb/tb_top.sv
